@@ src/stat_string_odd_byte_codec_assert.svh @@
// Assertion macros for the stat-string odd-byte codec checker.
// Depends on signals named clk and rst_n in the scope of use.
`ifndef STAT_STRING_ODD_BYTE_CODEC_ASSERT_SVH
`define STAT_STRING_ODD_BYTE_CODEC_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SOSB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SOSB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sosb_pkg.sv @@
// Shared types and constants of the stat-string odd-byte codec.
// No dependencies.
package sosb_pkg;

    localparam int GROUP_BYTES = 7;
    localparam logic [2:0] GROUP_LAST = 3'd6;
    localparam logic [7:0] MASK_INIT = 8'h01;

    // One job handed from the front to the back: a whole encode group, or a
    // single decoded byte carried in bytes[0].
    typedef struct packed {
        logic                              is_group;
        logic                              last;
        logic [2:0]                        count;
        logic [7:0]                        mask;
        logic [GROUP_BYTES-1:0][7:0]       bytes;
    } cmd_t;

endpackage

@@ src/sosb_in_if.sv @@
// Input channel of the stat-string odd-byte codec: valid/ready with one byte.
// No dependencies.
interface sosb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

@@ src/sosb_out_if.sv @@
// Output channel of the stat-string odd-byte codec: valid/ready with one byte.
// No dependencies.
interface sosb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

@@ src/sosb_front.sv @@
// Front of the codec: accepts input beats, tracks group position and mask,
// gathers encode groups and pushes jobs to the queue. Uses sosb_pkg, sosb_in_if.
module sosb_front (
    input  logic             clk,
    input  logic             rst_n,
    sosb_in_if.sink          rx,
    input  logic             cfg_we,
    input  logic             cfg_wdata,
    output logic             q_push,
    output sosb_pkg::cmd_t   q_data,
    input  logic             q_full
);

    logic       mode_reg, mode_next;
    logic [2:0] pos_reg, pos_next;
    logic [7:0] mask_reg, mask_next;
    logic [7:0] store_reg [sosb_pkg::GROUP_BYTES];

    logic       accept;
    logic [7:0] enc_byte;
    logic [7:0] enc_mask;
    logic [7:0] dec_byte;
    logic       group_done;

    assign rx.ready = !q_full;
    assign accept   = rx.valid && rx.ready;

    // Even bytes are stored plus one, odd bytes unchanged: either way the low bit is set.
    assign enc_byte   = rx.data_byte | 8'h01;
    assign enc_mask   = mask_reg | (rx.data_byte[0] ? (8'h02 << pos_reg) : 8'h00);
    assign dec_byte   = mask_reg[pos_reg] ? rx.data_byte : rx.data_byte - 8'd1;
    assign group_done = (pos_reg == sosb_pkg::GROUP_LAST) || rx.end_of_message;

    always_comb
    begin
        q_data.is_group = !mode_reg;
        q_data.last     = rx.end_of_message;
        q_data.count    = pos_reg;
        q_data.mask     = enc_mask;
        for (int k = 0; k < sosb_pkg::GROUP_BYTES; k++)
        begin
            q_data.bytes[k] = (pos_reg == 3'(k)) ? enc_byte : store_reg[k];
        end
        if (mode_reg)
        begin
            q_data.bytes[0] = dec_byte;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        pos_next  = pos_reg;
        mask_next = mask_reg;
        q_push    = 1'b0;
        if (cfg_we)
        begin
            mode_next = cfg_wdata;
            pos_next  = 3'd0;
            mask_next = sosb_pkg::MASK_INIT;
        end
        else if (accept)
        begin
            if (mode_reg)
            begin
                if (pos_reg == 3'd0)
                begin
                    mask_next = rx.data_byte;
                end
                else
                begin
                    q_push = 1'b1;
                end
                if (rx.end_of_message)
                begin
                    pos_next  = 3'd0;
                    mask_next = sosb_pkg::MASK_INIT;
                end
                else
                begin
                    pos_next = pos_reg + 3'd1;
                end
            end
            else if (group_done)
            begin
                q_push    = 1'b1;
                pos_next  = 3'd0;
                mask_next = sosb_pkg::MASK_INIT;
            end
            else
            begin
                pos_next  = pos_reg + 3'd1;
                mask_next = enc_mask;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            pos_reg  <= 3'd0;
            mask_reg <= sosb_pkg::MASK_INIT;
        end
        else
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !cfg_we && !mode_reg)
        begin
            store_reg[pos_reg] <= enc_byte;
        end
    end

endmodule

@@ src/sosb_queue.sv @@
// Short job queue between front and back of the codec.
// Uses sosb_pkg.
module sosb_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sosb_pkg::cmd_t   push_data,
    output logic             full,
    input  logic             pop,
    output sosb_pkg::cmd_t   pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sosb_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/sosb_back.sv @@
// Back of the codec: takes jobs from the queue and sends them out one byte
// per beat through an output register. Uses sosb_pkg, sosb_out_if.
module sosb_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sosb_pkg::cmd_t   q_data,
    input  logic             q_empty,
    output logic             q_pop,
    sosb_out_if.source       tx
);

    logic           busy_reg, busy_next;
    sosb_pkg::cmd_t cmd_reg, cmd_next;
    logic [2:0]     idx_reg, idx_next;
    logic           tx_valid_reg, tx_valid_next;
    logic [7:0]     tx_byte_reg, tx_byte_next;
    logic           tx_last_reg, tx_last_next;

    logic       out_free;
    logic       emit;
    logic       finishing;
    logic [2:0] slot;
    logic [7:0] cur_byte;
    logic       cur_last;

    assign out_free = !tx_valid_reg || tx.ready;
    assign emit     = busy_reg && out_free;
    // Index 0 of a group is the mask; data slots follow it.
    assign slot     = idx_reg - 3'd1;

    always_comb
    begin
        if (!cmd_reg.is_group)
        begin
            cur_byte  = cmd_reg.bytes[0];
            cur_last  = cmd_reg.last;
            finishing = 1'b1;
        end
        else if (idx_reg == 3'd0)
        begin
            cur_byte  = cmd_reg.mask;
            cur_last  = 1'b0;
            finishing = 1'b0;
        end
        else
        begin
            cur_byte  = cmd_reg.bytes[slot];
            finishing = (slot == cmd_reg.count);
            cur_last  = cmd_reg.last && finishing;
        end
    end

    assign q_pop = !q_empty && (!busy_reg || (emit && finishing));

    always_comb
    begin
        busy_next     = busy_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        tx_valid_next = tx_valid_reg && !tx.ready;
        tx_byte_next  = tx_byte_reg;
        tx_last_next  = tx_last_reg;
        if (emit)
        begin
            tx_valid_next = 1'b1;
            tx_byte_next  = cur_byte;
            tx_last_next  = cur_last;
            idx_next      = idx_reg + 3'd1;
            if (finishing)
            begin
                busy_next = 1'b0;
            end
        end
        // Load the next job in the same cycle the current one drains.
        if (q_pop)
        begin
            busy_next = 1'b1;
            cmd_next  = q_data;
            idx_next  = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            idx_reg      <= 3'd0;
            tx_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            idx_reg      <= idx_next;
            tx_valid_reg <= tx_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        tx_byte_reg <= tx_byte_next;
        tx_last_reg <= tx_last_next;
    end

    assign tx.valid    = tx_valid_reg;
    assign tx.out_byte = tx_byte_reg;
    assign tx.out_last = tx_last_reg;

endmodule

@@ src/stat_string_odd_byte_codec.sv @@
// Stat-string odd-byte codec. In encode mode (cfg_wdata written as 0) input bytes
// are gathered in groups of up to seven and each group leaves as a mask byte
// followed by its bytes, all odd; in decode mode every eighth byte of a
// message is a mask and the others leave adjusted by it. The front accepts
// one beat per cycle while its job queue has room, so decode runs at one
// byte per cycle; in encode the back sends one byte per cycle out of its
// output register while tx is ready, and a group of n bytes leaves as n + 1
// bytes, so the sustained encode rate is set by the single output port.
// A byte reaches tx through the queue entry written when its job completes,
// then the back's job register, then the output register. Write cfg only
// while the block is idle; a write drops any partial group.
module stat_string_odd_byte_codec #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    sosb_in_if.sink     rx,
    sosb_out_if.source  tx,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;
    sosb_pkg::cmd_t push_data;
    sosb_pkg::cmd_t pop_data;

    sosb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_push    (q_push),
        .q_data    (push_data),
        .q_full    (q_full)
    );

    sosb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    sosb_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (pop_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .tx      (tx)
    );

endmodule

@@ src/sosb_checker.sv @@
// Port-level checks of the stat-string odd-byte codec, bound to its top level.
// Depends on stat_string_odd_byte_codec_assert.svh.
`include "stat_string_odd_byte_codec_assert.svh"

module sosb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_we,
    input logic       cfg_wdata,
    input logic       tx_valid,
    input logic       tx_ready,
    input logic [7:0] tx_byte,
    input logic       tx_last
);

    logic mode_reg;

    // Track the mode the block was last set to.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    `SOSB_ASSERT_NEXT(a_tx_valid_hold, tx_valid && !tx_ready, tx_valid, "tx beat dropped while stalled")
    `SOSB_ASSERT_NEXT(a_tx_data_hold, tx_valid && !tx_ready, $stable(tx_byte) && $stable(tx_last), "tx payload changed while stalled")
    `SOSB_ASSERT_NOW(a_enc_odd, !mode_reg && tx_valid, tx_byte[0], "encoded beat is even")
    `SOSB_ASSERT_NEXT(a_enc_mask_after_last, !mode_reg && tx_valid && tx_ready && tx_last, !(tx_valid && tx_last), "encode beat after message end is not a mask")

endmodule

bind stat_string_odd_byte_codec sosb_checker u_sosb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tx_valid  (tx.valid),
    .tx_ready  (tx.ready),
    .tx_byte   (tx.out_byte),
    .tx_last   (tx.out_last)
);
